>>> hdl/rmf_pkg.sv
// Package for the RGB 3x3 median filter: payload structs, job types,
// sizing constants and the small compare functions used by the sorter.
// No dependencies.
package rmf_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 2048;
  localparam int unsigned CFG_W          = 12;
  localparam int unsigned COORD_W        = 11;
  localparam int unsigned QDEPTH         = 4;
  localparam int unsigned QPTR_W         = 2;
  localparam int unsigned QCNT_W         = 3;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               last_in_run;
    logic               frame_end;
  } out_t;

  // Request bits: 0 = (r-1,c-1), 1 = (r-1,c), 2 = (r,c-1), 3 = (r,c).
  typedef struct packed {
    logic [3:0]         emit;
    logic               med;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [3:0][23:0]   pass;
  } meta_t;

  typedef struct packed {
    logic [8:0][23:0] nine;
    meta_t            meta;
  } job_t;

  // Returns {max, mid, min}.
  function automatic logic [23:0] sort3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    logic [7:0] lo, hi, t;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) begin
      t = lo;
      lo = c;
      return {hi, t, lo};
    end else if (c > hi) begin
      return {c, hi, lo};
    end
    return {hi, c, lo};
  endfunction

  function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [7:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    logic [23:0] s;
    s = sort3(a, b, c);
    return s[15:8];
  endfunction

endpackage

>>> hdl/rmf_front.sv
// Front end of the median filter: accepts pixels, keeps the raster counters,
// the line buffer memory and the 3x3 window, and builds a job per pixel that has results due.
// Depends on rmf_pkg.
module rmf_front #(
  parameter int unsigned MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = rmf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [rmf_pkg::CFG_W-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  rmf_pkg::in_t             in_data,
  input  logic [rmf_pkg::QCNT_W-1:0] q_count,
  output logic                     q_push,
  output rmf_pkg::job_t            q_job
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned SW = 15;

  logic [rmf_pkg::CFG_W-1:0] width_r, height_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [SW-1:0] wcl, hcl;
  logic [CW-1:0] wlast;
  logic [RW-1:0] hlast;
  logic lastc, lastr, acc;

  logic          f_v_r;
  logic [23:0]   f_pix_r;
  logic [CW-1:0] f_idx_r;
  rmf_pkg::meta_t f_meta_r, f_meta_nxt;

  logic [47:0] line_mem [MAX_WIDTH];
  logic [47:0] rd_r;
  logic [5:0][23:0] win_r;
  logic [23:0] cur0, cur1;

  always_comb begin
    if (width_r < 12'd3) wcl = SW'(3);
    else if (SW'(width_r) > SW'(MAX_WIDTH)) wcl = SW'(MAX_WIDTH);
    else wcl = SW'(width_r);
    if (height_r < 12'd3) hcl = SW'(3);
    else if (SW'(height_r) > SW'(MAX_HEIGHT)) hcl = SW'(MAX_HEIGHT);
    else hcl = SW'(height_r);
  end

  assign wlast = CW'(wcl - SW'(1));
  assign hlast = RW'(hcl - SW'(1));
  assign lastc = col_r >= wlast;
  assign lastr = row_r >= hlast;

  // The queue must have room for the item in flight plus this one.
  assign in_ready = ({1'b0, q_count} + {3'b000, f_v_r}) < 4'(rmf_pkg::QDEPTH);
  assign acc      = in_valid && in_ready;

  always_comb begin
    f_meta_nxt.emit[0] = (row_r != '0) && (col_r != '0);
    f_meta_nxt.emit[1] = (row_r != '0) && lastc;
    f_meta_nxt.emit[2] = lastr && (col_r != '0);
    f_meta_nxt.emit[3] = lastr && lastc;
    f_meta_nxt.med     = (row_r >= RW'(2)) && (col_r >= CW'(2));
    f_meta_nxt.row     = rmf_pkg::COORD_W'(row_r);
    f_meta_nxt.col     = rmf_pkg::COORD_W'(col_r);
    f_meta_nxt.pass    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rmf_pkg::CFG_W'(640);
      height_r <= rmf_pkg::CFG_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        rmf_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        rmf_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= acc;
      if (acc) begin
        if (lastc) begin
          col_r <= '0;
          row_r <= lastr ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f_pix_r  <= in_data;
      f_idx_r  <= col_r;
      f_meta_r <= f_meta_nxt;
    end
  end

  // Line buffers: older row in the upper half, newer row in the lower half.
  always_ff @(posedge clk) begin
    if (acc) rd_r <= line_mem[col_r];
    if (f_v_r) line_mem[f_idx_r] <= {cur1, f_pix_r};
  end

  assign cur0 = rd_r[47:24];
  assign cur1 = rd_r[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (f_v_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= cur0;
      win_r[4] <= cur1;
      win_r[5] <= f_pix_r;
    end
  end

  always_comb begin
    q_job.nine[0] = win_r[0];
    q_job.nine[1] = win_r[1];
    q_job.nine[2] = win_r[2];
    q_job.nine[3] = win_r[3];
    q_job.nine[4] = win_r[4];
    q_job.nine[5] = win_r[5];
    q_job.nine[6] = cur0;
    q_job.nine[7] = cur1;
    q_job.nine[8] = f_pix_r;
    q_job.meta      = f_meta_r;
    q_job.meta.pass = {f_pix_r, win_r[5], cur1, win_r[4]};
  end

  assign q_push = f_v_r && (f_meta_r.emit != 4'b0000);

  a_step_col: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !lastc |=> col_r == $past(col_r) + CW'(1))
    else $error("column counter did not advance");
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    acc && lastc |=> col_r == '0)
    else $error("column counter did not wrap at row end");

endmodule

>>> hdl/rmf_queue.sv
// Short job queue between the front end and the median back end.
// Depends on rmf_pkg.
module rmf_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  rmf_pkg::job_t              push_job,
  input  logic                       pop,
  output logic                       q_valid,
  output rmf_pkg::job_t              q_job,
  output logic [rmf_pkg::QCNT_W-1:0] count
);

  rmf_pkg::job_t slot_r [rmf_pkg::QDEPTH];
  logic [rmf_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [rmf_pkg::QCNT_W-1:0] cnt_r;
  logic do_pop;

  assign do_pop  = pop && (cnt_r != '0);
  assign q_valid = cnt_r != '0;
  assign q_job   = slot_r[rp_r];
  assign count   = cnt_r;

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + rmf_pkg::QPTR_W'(1);
      if (do_pop) rp_r <= rp_r + rmf_pkg::QPTR_W'(1);
      cnt_r <= cnt_r + rmf_pkg::QCNT_W'(push) - rmf_pkg::QCNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < rmf_pkg::QCNT_W'(rmf_pkg::QDEPTH)) || do_pop)
    else $error("job queue overflow");

endmodule

>>> hdl/rmf_back.sv
// Back end of the median filter: three-stage median of nine per channel
// (column sort, min/med/max reduce, final median) and the result expander.
// Depends on rmf_pkg.
module rmf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  rmf_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output rmf_pkg::out_t out_data
);

  logic s1_v_r, s2_v_r, s3_v_r;
  logic rdy1, rdy2, rdy3;
  logic [2:0][2:0][23:0] s1_srt_r;   // [column][channel] = {max, mid, min}
  logic [2:0][23:0] s2_lmh_r;        // [channel] = {min of max, med of mid, max of min}
  rmf_pkg::meta_t s1_meta_r, s2_meta_r;
  logic [3:0][23:0] s3_pix_r;
  logic [3:0] s3_mask_r;
  logic [rmf_pkg::COORD_W-1:0] s3_row_r, s3_col_r;
  logic [3:0] sel;
  logic last, take;
  logic [23:0] med_pix, opix;

  assign take = out_valid && out_ready;
  assign rdy3 = !s3_v_r || (out_ready && last);
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign q_pop = q_valid && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= q_valid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_meta_r <= q_job.meta;
      for (int k = 0; k < 3; k++) begin
        for (int ch = 0; ch < 3; ch++) begin
          s1_srt_r[k][ch] <= rmf_pkg::sort3(q_job.nine[3*k][8*ch +: 8],
                                            q_job.nine[3*k+1][8*ch +: 8],
                                            q_job.nine[3*k+2][8*ch +: 8]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_meta_r <= s1_meta_r;
      for (int ch = 0; ch < 3; ch++) begin
        s2_lmh_r[ch] <= {
          rmf_pkg::min3(s1_srt_r[0][ch][23:16], s1_srt_r[1][ch][23:16],
                        s1_srt_r[2][ch][23:16]),
          rmf_pkg::med3(s1_srt_r[0][ch][15:8], s1_srt_r[1][ch][15:8],
                        s1_srt_r[2][ch][15:8]),
          rmf_pkg::max3(s1_srt_r[0][ch][7:0], s1_srt_r[1][ch][7:0],
                        s1_srt_r[2][ch][7:0])};
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      med_pix[8*ch +: 8] = rmf_pkg::med3(s2_lmh_r[ch][23:16], s2_lmh_r[ch][15:8],
                                         s2_lmh_r[ch][7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_pix_r <= {s2_meta_r.pass[3:1],
                   (s2_meta_r.med ? med_pix : s2_meta_r.pass[0])};
      s3_row_r <= s2_meta_r.row;
      s3_col_r <= s2_meta_r.col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_mask_r <= '0;
    end else if (rdy3) begin
      s3_mask_r <= s2_v_r ? s2_meta_r.emit : 4'b0000;
    end else if (take) begin
      s3_mask_r <= s3_mask_r & ~sel;
    end
  end

  // Lowest pending request goes out first.
  always_comb begin
    sel = s3_mask_r & (~s3_mask_r + 4'd1);
    last = (s3_mask_r & ~sel) == 4'b0000;
  end

  always_comb begin
    opix = s3_pix_r[0];
    out_data.out_row = s3_row_r;
    out_data.out_col = s3_col_r;
    case (sel)
      4'b0001: begin
        opix = s3_pix_r[0];
        out_data.out_row = s3_row_r - rmf_pkg::COORD_W'(1);
        out_data.out_col = s3_col_r - rmf_pkg::COORD_W'(1);
      end
      4'b0010: begin
        opix = s3_pix_r[1];
        out_data.out_row = s3_row_r - rmf_pkg::COORD_W'(1);
      end
      4'b0100: begin
        opix = s3_pix_r[2];
        out_data.out_col = s3_col_r - rmf_pkg::COORD_W'(1);
      end
      4'b1000: opix = s3_pix_r[3];
      default: ;
    endcase
    out_data.red_out     = opix[23:16];
    out_data.green_out   = opix[15:8];
    out_data.blue_out    = opix[7:0];
    out_data.last_in_run = last;
    out_data.frame_end   = sel[3];
  end

  assign out_valid = s3_v_r;

  a_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> s3_mask_r != 4'b0000)
    else $error("result stage valid with no pending request");
  a_sel_one: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> $onehot(sel))
    else $error("result select not one-hot");

endmodule

>>> hdl/rgb_median_filter_3x3.sv
// Top level of the RGB 3x3 median filter: front end, job queue, back end.
// Depends on rmf_pkg, rmf_front, rmf_queue and rmf_back.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------
//  in      | in_valid / in_ready    | in_data  (rmf_pkg::in_t)
//  out     | out_valid / out_ready  | out_data (rmf_pkg::out_t)
//  cfg     | cfg_we                 | cfg_index, cfg_data (12 bit)
//
// One pixel is accepted per clock while the queue has room; interior and
// first-row pixels give at most one result each, so with out_ready high the
// stream runs at one pixel per cycle. On the last column or row a pixel off
// the first row and column gives two or four results, one per cycle from the
// result stage; the four-entry job queue soaks up that burst. A result leaves
// after front register with line-buffer read, queue slot, three median stages.
// Reset is synchronous and clears all control state.
module rgb_median_filter_3x3 #(
  parameter int unsigned MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = rmf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [rmf_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rmf_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rmf_pkg::out_t             out_data
);

  logic q_push, q_pop, q_valid;
  rmf_pkg::job_t push_job, q_job;
  logic [rmf_pkg::QCNT_W-1:0] q_count;

  rmf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  rmf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_job   (q_job),
    .count   (q_count)
  );

  rmf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

>>> tb/tb_rgb_median_filter_3x3.sv
// Self-checking testbench for rgb_median_filter_3x3: drives pixel frames and
// compares every result against a cycle-free predictor of the 3x3 median filter.
// Depends on rmf_pkg and the RTL of rgb_median_filter_3x3.
`timescale 1ns / 1ps

module tb_rgb_median_filter_3x3;

  localparam int LINE_MAX = 2048;
  localparam int SETTLE_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [rmf_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  rmf_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rmf_pkg::out_t out_data;

  rgb_median_filter_3x3 u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Predictor state: two line buffers, a 3x2 window and the raster position.
  logic [23:0] line_above2 [LINE_MAX];
  logic [23:0] line_above1 [LINE_MAX];
  logic [23:0] win_cols [6];
  int pos_row, pos_col;
  logic [rmf_pkg::CFG_W-1:0] shadow_width = 12'd640;
  logic [rmf_pkg::CFG_W-1:0] shadow_height = 12'd480;

  rmf_pkg::in_t pixel_q[$];
  rmf_pkg::out_t expected_q[$];
  int idle_mode = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int frames_sent = 0;

  function automatic int clamp_dim(logic [rmf_pkg::CFG_W-1:0] v);
    if (v < 3) return 3;
    if (v > LINE_MAX) return LINE_MAX;
    return int'(v);
  endfunction

  function automatic logic [7:0] median_of_nine(logic [8:0][7:0] v);
    logic [7:0] s [9];
    logic [7:0] t;
    for (int i = 0; i < 9; i++) s[i] = v[i];
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8 - i; j++)
        if (s[j] > s[j+1]) begin
          t = s[j];
          s[j] = s[j+1];
          s[j+1] = t;
        end
    return s[4];
  endfunction

  function automatic rmf_pkg::out_t make_result(logic [23:0] pix, int row, int col,
                                                logic fend);
    rmf_pkg::out_t o;
    o.red_out = pix[23:16];
    o.green_out = pix[15:8];
    o.blue_out = pix[7:0];
    o.out_row = row[rmf_pkg::COORD_W-1:0];
    o.out_col = col[rmf_pkg::COORD_W-1:0];
    o.last_in_run = 1'b0;
    o.frame_end = fend;
    return o;
  endfunction

  task automatic predict_pixel(rmf_pkg::in_t p);
    int w, h, r, c, n, ch;
    logic [23:0] pin, above2, above1, val;
    logic [8:0][7:0] chan;
    logic [8:0][23:0] nine;
    logic lastc, lastr;
    rmf_pkg::out_t res [4];
    w = clamp_dim(shadow_width);
    h = clamp_dim(shadow_height);
    r = pos_row;
    c = pos_col;
    pin = {p.red_in, p.green_in, p.blue_in};
    above2 = line_above2[c % LINE_MAX];
    above1 = line_above1[c % LINE_MAX];
    lastc = (c >= w - 1);
    lastr = (r >= h - 1);
    n = 0;
    if (r >= 1 && c >= 1) begin
      if (r >= 2 && c >= 2) begin
        for (int i = 0; i < 6; i++) nine[i] = win_cols[i];
        nine[6] = above2;
        nine[7] = above1;
        nine[8] = pin;
        for (ch = 0; ch < 3; ch++) begin
          for (int i = 0; i < 9; i++) chan[i] = nine[i][ch*8 +: 8];
          val[ch*8 +: 8] = median_of_nine(chan);
        end
      end else begin
        val = win_cols[4];
      end
      res[n] = make_result(val, r - 1, c - 1, 1'b0);
      n++;
    end
    if (r >= 1 && lastc) begin
      res[n] = make_result(above1, r - 1, c, 1'b0);
      n++;
    end
    if (lastr && c >= 1) begin
      res[n] = make_result(win_cols[5], r, c - 1, 1'b0);
      n++;
    end
    if (lastr && lastc) begin
      res[n] = make_result(pin, r, c, 1'b1);
      n++;
    end
    if (n > 0) res[n-1].last_in_run = 1'b1;
    for (int i = 0; i < n; i++) expected_q.push_back(res[i]);

    line_above2[c % LINE_MAX] = above1;
    line_above1[c % LINE_MAX] = pin;
    for (int i = 0; i < 3; i++) win_cols[i] = win_cols[i+3];
    win_cols[3] = above2;
    win_cols[4] = above1;
    win_cols[5] = pin;
    if (lastc) begin
      pos_col = 0;
      pos_row = lastr ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
  endtask

  function automatic bit sender_idles();
    case (idle_mode)
      0: return $urandom_range(99) < 38;
      1: return $urandom_range(99) < 86;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_idles();
    case (idle_mode)
      0: return $urandom_range(99) < 86;
      1: return $urandom_range(99) < 38;
      default: return 1'b0;
    endcase
  endfunction

  // Driver: a request stays up with its payload until the block takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_pixel(in_data);
        pixels_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pixel_q.size() > 0 && !sender_idles()) begin
          in_valid <= 1'b1;
          in_data <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, rmf_pkg::out_t got, rmf_pkg::out_t want);
    mismatches++;
    $display("MISMATCH %s: got %h (%0d,%0d) %b%b, want %h (%0d,%0d) %b%b",
             what, {got.red_out, got.green_out, got.blue_out}, got.out_row,
             got.out_col, got.last_in_run, got.frame_end,
             {want.red_out, want.green_out, want.blue_out}, want.out_row,
             want.out_col, want.last_in_run, want.frame_end);
  endtask

  // Monitor: random back-pressure, then field-by-field compare.
  always @(posedge clk) begin
    rmf_pkg::out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_data, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.red_out !== want.red_out) report_mismatch("red", out_data, want);
          else if (out_data.green_out !== want.green_out)
            report_mismatch("green", out_data, want);
          else if (out_data.blue_out !== want.blue_out) report_mismatch("blue", out_data, want);
          else if (out_data.out_row !== want.out_row) report_mismatch("row", out_data, want);
          else if (out_data.out_col !== want.out_col) report_mismatch("col", out_data, want);
          else if (out_data.last_in_run !== want.last_in_run)
            report_mismatch("last_in_run", out_data, want);
          else if (out_data.frame_end !== want.frame_end)
            report_mismatch("frame_end", out_data, want);
        end
      end
      out_ready <= !receiver_idles();
    end
  end

  task automatic write_reg(logic idx, logic [rmf_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == rmf_pkg::CFG_IMAGE_WIDTH) shadow_width = val;
    else shadow_height = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sampled at the falling edge so that the driver's updates have settled.
  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_valid || expected_q.size() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic rmf_pkg::in_t random_pixel();
    rmf_pkg::in_t p;
    case ($urandom_range(7))
      0: p = '0;
      1: p = '1;
      default: p = rmf_pkg::in_t'(24'($urandom));
    endcase
    return p;
  endfunction

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pixel_q.push_back(random_pixel());
  endtask

  task automatic run_frame(logic [rmf_pkg::CFG_W-1:0] w, logic [rmf_pkg::CFG_W-1:0] h);
    write_reg(rmf_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, h);
    queue_random(clamp_dim(w) * clamp_dim(h));
    wait_idle();
    frames_sent++;
  endtask

  initial begin
    rmf_pkg::in_t p;
    for (int i = 0; i < LINE_MAX; i++) begin
      line_above2[i] = '0;
      line_above1[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_cols[i] = '0;
    pos_row = 0;
    pos_col = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest frame with extreme channel values; the center is a true median.
    idle_mode = 0;
    write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 12'd3);
    write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, 12'd3);
    for (int i = 0; i < 9; i++) begin
      p.red_in = (i % 2) ? 8'hFF : 8'h00;
      p.green_in = 8'(i * 31);
      p.blue_in = (i == 4) ? 8'h80 : ((i < 4) ? 8'h00 : 8'hFF);
      pixel_q.push_back(p);
    end
    wait_idle();
    frames_sent++;

    // Sizes below the minimum clamp to three.
    run_frame(12'd0, 12'd4);
    run_frame(12'd5, 12'd0);

    // Width shrinks while row zero is past the new last column.
    idle_mode = 1;
    write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 12'd12);
    write_reg(rmf_pkg::CFG_IMAGE_HEIGHT, 12'd4);
    queue_random(8);
    wait_idle();
    write_reg(rmf_pkg::CFG_IMAGE_WIDTH, 12'd4);
    queue_random(1 + 3 * 4);
    wait_idle();
    frames_sent++;

    while (pixels_sent < 95) run_frame(12'($urandom_range(3, 8)), 12'($urandom_range(3, 6)));

    // Full rate on both sides.
    idle_mode = 2;
    run_frame(12'd3, 12'd4);
    run_frame(12'($urandom_range(3, 5)), 12'($urandom_range(3, 4)));

    $display("Sent %0d pixels in %0d frames (3x3 to 12 wide, clamped and shrunk sizes),",
             pixels_sent, frames_sent);
    $display("checked %0d results under three back-pressure mixes.", results_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("rgb_median_filter_3x3 test passed");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, expected_q.size());
      $display("rgb_median_filter_3x3 test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected.", expected_q.size());
    $display("rgb_median_filter_3x3 test failed");
    $finish;
  end

endmodule
